/* rtl/amss_pkg.sv */
package amss_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 10;
  localparam int REF_BITS            = 14;
  localparam logic [REF_BITS-1:0] REF_RESET = 14'd5000;

  // sample * reference >> SAMPLE_BITS always stays below 2^REF_BITS
  localparam int MV_BITS    = REF_BITS;
  localparam int DIGIT_BITS = 4;

  // divide by ten as (x * 52429) >> 19, exact for x below 43699
  localparam int DIV_BITS    = 16;
  localparam logic [DIV_BITS-1:0] DIV10_MUL = 16'd52429;
  localparam int DIV10_SHIFT = 19;
  localparam int Q1_BITS     = 11;  // mv / 10 below 1639
  localparam int Q2_BITS     = 8;   // mv / 100 below 164
  localparam int Q3_BITS     = 5;   // mv / 1000 below 17

  localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = 4'd9;
  localparam logic [7:0] SEG_DP_CLEAR = 8'h7F;
  localparam logic [7:0] SEG_BLANK    = 8'hFF;

  localparam logic [3:0] SEL_ONES      = 4'b1000;
  localparam logic [3:0] SEL_TENS      = 4'b0100;
  localparam logic [3:0] SEL_HUNDREDS  = 4'b0010;
  localparam logic [3:0] SEL_THOUSANDS = 4'b0001;

  typedef enum logic [1:0] {
    POS_ONES      = 2'd0,
    POS_TENS      = 2'd1,
    POS_HUNDREDS  = 2'd2,
    POS_THOUSANDS = 2'd3
  } digit_pos_t;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] thousands;
    logic [DIGIT_BITS-1:0] hundreds;
    logic [DIGIT_BITS-1:0] tens;
    logic [DIGIT_BITS-1:0] ones;
  } digits_t;

  // active-low common-anode patterns, bit 0 = a ... bit 6 = g
  function automatic logic [7:0] seg_pattern(input logic [DIGIT_BITS-1:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0: pat = 8'hC0;
      4'd1: pat = 8'hF9;
      4'd2: pat = 8'hA4;
      4'd3: pat = 8'hB0;
      4'd4: pat = 8'h99;
      4'd5: pat = 8'h92;
      4'd6: pat = 8'h82;
      4'd7: pat = 8'hF8;
      4'd8: pat = 8'h80;
      4'd9: pat = 8'h90;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

endpackage

/* rtl/adc_millivolt_seven_segment.sv */
// Converts each converter sample to millivolts, floor(sample * reference / 2^SAMPLE_BITS),
// and sends it as four display transactions, ones digit first and thousands last, each
// with an active-low segment pattern and a one-hot digit select; the thousands digit has
// its decimal point lit and saturates at nine. The first transaction of a sample leaves
// after the sample has passed one multiply stage, four digit-split stages and one output
// register. The output channel takes four transactions per sample; while one is held, the
// next is loaded only as its thousands transaction leaves. Up to six samples can be in flight.
// reference_millivolts resets to 5000 and is written through cfg_write / cfg_data.
module adc_millivolt_seven_segment import amss_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [REF_BITS-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             segments,
  output logic [3:0]             digit_select,
  output logic                   last
);

  logic [REF_BITS-1:0] reference_millivolts;

  logic               mv_valid, mv_stall;
  logic [MV_BITS-1:0] mv;
  logic               dig_valid, dig_stall;
  digits_t            digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_millivolts <= REF_RESET;
    end else if (cfg_write) begin
      reference_millivolts <= cfg_data;
    end
  end

  amss_scale #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .reference (reference_millivolts),
    .out_valid (mv_valid),
    .out_stall (mv_stall),
    .mv        (mv)
  );

  amss_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mv_valid),
    .in_stall  (mv_stall),
    .mv        (mv),
    .out_valid (dig_valid),
    .out_stall (dig_stall),
    .digits    (digits)
  );

  amss_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dig_valid),
    .in_stall     (dig_stall),
    .digits       (digits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segments     (segments),
    .digit_select (digit_select),
    .last         (last)
  );

  // a sample is never cut short: after a non-final digit another digit follows
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && !$past(last) && !last
      || out_valid && digit_select == SEL_THOUSANDS)
    else $error("sample split before its thousands digit");

  // the decimal point is lit on the thousands digit only
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (segments[7] == !last))
    else $error("decimal point on wrong digit");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(digit_select) && (last == (digit_select == SEL_THOUSANDS)))
    else $error("digit select inconsistent with last");

  // the digit order runs ones, tens, hundreds, thousands; this checks that tens follows ones
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && digit_select == SEL_ONES |=>
      out_valid && digit_select == SEL_TENS)
    else $error("tens digit does not follow ones digit");

endmodule

/* rtl/amss_scale.sv */
module amss_scale import amss_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [REF_BITS-1:0]    reference,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MV_BITS-1:0]     mv
);

  localparam int PROD_BITS = SAMPLE_BITS + REF_BITS;

  logic                 valid;
  logic [PROD_BITS-1:0] product;
  logic                 en;

  assign en       = !valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      product <= PROD_BITS'(sample) * PROD_BITS'(reference);
    end
  end

  assign out_valid = valid;
  // dropping the low sample bits is the divide by full scale
  assign mv        = product[SAMPLE_BITS +: MV_BITS];

endmodule

/* rtl/amss_digits.sv */
module amss_digits import amss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MV_BITS-1:0] mv,
  output logic               out_valid,
  input  logic               out_stall,
  output digits_t            digits
);

  localparam int P1_BITS = MV_BITS + DIV_BITS;
  localparam int P2_BITS = Q1_BITS + DIV_BITS;
  localparam int P3_BITS = Q2_BITS + DIV_BITS;

  logic a_v, b_v, c_v, d_v;
  logic en_a, en_b, en_c, en_d;

  logic [MV_BITS-1:0]    a_mv;
  logic [Q1_BITS-1:0]    a_q1, b_q1;
  logic [Q2_BITS-1:0]    b_q2, c_q2;
  logic [Q3_BITS-1:0]    c_q3;
  logic [DIGIT_BITS-1:0] b_ones, c_ones, c_tens;

  logic [P1_BITS-1:0] p1;
  logic [P2_BITS-1:0] p2;
  logic [P3_BITS-1:0] p3;
  logic [MV_BITS-1:0] ones_full;
  logic [Q1_BITS-1:0] tens_full;
  logic [Q2_BITS-1:0] hund_full;

  assign en_d     = !d_v || !out_stall;
  assign en_c     = !c_v || en_d;
  assign en_b     = !b_v || en_c;
  assign en_a     = !a_v || en_b;
  assign in_stall = !en_a;

  assign p1        = P1_BITS'(mv) * P1_BITS'(DIV10_MUL);
  assign p2        = P2_BITS'(a_q1) * P2_BITS'(DIV10_MUL);
  assign ones_full = a_mv - MV_BITS'(a_q1) * MV_BITS'(10);
  assign p3        = P3_BITS'(b_q2) * P3_BITS'(DIV10_MUL);
  assign tens_full = b_q1 - Q1_BITS'(b_q2) * Q1_BITS'(10);
  assign hund_full = c_q2 - Q2_BITS'(c_q3) * Q2_BITS'(10);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (en_a) a_v <= in_valid;
      if (en_b) b_v <= a_v;
      if (en_c) c_v <= b_v;
      if (en_d) d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_mv <= mv;
      a_q1 <= p1[DIV10_SHIFT +: Q1_BITS];
    end
    if (en_b && a_v) begin
      b_q1   <= a_q1;
      b_q2   <= p2[DIV10_SHIFT +: Q2_BITS];
      b_ones <= ones_full[DIGIT_BITS-1:0];
    end
    if (en_c && b_v) begin
      c_q2   <= b_q2;
      c_q3   <= p3[DIV10_SHIFT +: Q3_BITS];
      c_ones <= b_ones;
      c_tens <= tens_full[DIGIT_BITS-1:0];
    end
    if (en_d && c_v) begin
      digits.ones     <= c_ones;
      digits.tens     <= c_tens;
      digits.hundreds <= hund_full[DIGIT_BITS-1:0];
      // thousands saturates at nine
      digits.thousands <= (c_q3 > Q3_BITS'(DIGIT_MAX)) ? DIGIT_MAX
                                                        : c_q3[DIGIT_BITS-1:0];
    end
  end

  assign out_valid = d_v;

endmodule

/* rtl/amss_serial.sv */
module amss_serial import amss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  digits_t    digits,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] segments,
  output logic [3:0] digit_select,
  output logic       last
);

  logic       valid;
  digit_pos_t pos;
  digits_t    held;
  logic       take;
  logic       load;
  logic [DIGIT_BITS-1:0] cur;

  assign take     = valid && !out_stall;
  // while a sample is held, the next one enters only as its thousands transaction leaves
  assign in_stall = valid && !(take && pos == POS_THOUSANDS);
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pos   <= POS_ONES;
    end else if (load) begin
      valid <= 1'b1;
      pos   <= POS_ONES;
    end else if (take) begin
      if (pos == POS_THOUSANDS) begin
        valid <= 1'b0;
        pos   <= POS_ONES;
      end else begin
        pos <= digit_pos_t'(pos + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= digits;
    end
  end

  always_comb begin
    case (pos)
      POS_ONES: begin
        cur          = held.ones;
        digit_select = SEL_ONES;
      end
      POS_TENS: begin
        cur          = held.tens;
        digit_select = SEL_TENS;
      end
      POS_HUNDREDS: begin
        cur          = held.hundreds;
        digit_select = SEL_HUNDREDS;
      end
      POS_THOUSANDS: begin
        cur          = held.thousands;
        digit_select = SEL_THOUSANDS;
      end
      default: begin
        cur          = held.ones;
        digit_select = SEL_ONES;
      end
    endcase
  end

  assign last      = (pos == POS_THOUSANDS);
  assign segments  = last ? (seg_pattern(cur) & SEG_DP_CLEAR) : seg_pattern(cur);
  assign out_valid = valid;

endmodule

/* dv/adc_millivolt_seven_segment_tb.sv */
`timescale 1ns / 1ps

module adc_millivolt_seven_segment_tb;
  import amss_pkg::*;

  localparam int SAMPLE_W     = SAMPLE_BITS_DEFAULT;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 72;
  localparam int SETTLE_TICKS = 16;
  localparam int IDLE_PCT     = 6;

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_select;
    logic       last;
  } display_digit_t;

  // segs packs the four patterns as {thousands, hundreds, tens, ones}
  typedef struct packed {
    logic                set_ref;
    logic [REF_BITS-1:0] value;
    logic                typed;
    logic [31:0]         segs;
  } directed_row_t;

  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  localparam int DIRECTED_ROWS = 22;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 14'd0,     1'b1, 32'h40C0C0C0},  // reference still at its reset value
    '{1'b0, 14'd1023,  1'b1, 32'h19909092},
    '{1'b0, 14'd512,   1'b1, 32'h2492C0C0},
    '{1'b0, 14'd1,     1'b1, 32'h40C0C099},
    '{1'b0, 14'd682,   1'b0, 32'h0},
    '{1'b0, 14'd341,   1'b0, 32'h0},
    '{1'b1, 14'd9999,  1'b0, 32'h0},
    '{1'b0, 14'd1023,  1'b1, 32'h10908090},
    '{1'b0, 14'd0,     1'b1, 32'h40C0C0C0},
    '{1'b1, 14'd0,     1'b0, 32'h0},
    '{1'b0, 14'd1023,  1'b1, 32'h40C0C0C0},
    // reference beyond 9999, thousands digit saturates
    '{1'b1, 14'd16383, 1'b0, 32'h0},
    '{1'b0, 14'd1023,  1'b1, 32'h10B082F8},
    '{1'b0, 14'd640,   1'b1, 32'h10A4B090},
    '{1'b0, 14'd300,   1'b0, 32'h0},
    // one millivolt per count, so every glyph shows up
    '{1'b1, 14'd1024,  1'b0, 32'h0},
    '{1'b0, 14'd1023,  1'b1, 32'h79C0A4B0},
    '{1'b0, 14'd987,   1'b0, 32'h0},
    '{1'b0, 14'd654,   1'b0, 32'h0},
    '{1'b0, 14'd321,   1'b0, 32'h0},
    '{1'b1, 14'd1,     1'b0, 32'h0},
    '{1'b0, 14'd1023,  1'b0, 32'h0}
  };

  localparam logic [REF_BITS-1:0] PHASE_REF [PHASES-1] = '{
    14'd5000, 14'd9999, 14'd0, 14'd16383, 14'd1024
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  logic [REF_BITS-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          segments;
  logic [3:0]          digit_select;
  logic                last;

  logic [REF_BITS-1:0] reference_mv = REF_RESET;
  display_digit_t      pending_digits [$];
  display_digit_t      oldest;
  bit                  steady_run = 1'b0;
  int unsigned         fail_count = 0;

  adc_millivolt_seven_segment dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segments     (segments),
    .digit_select (digit_select),
    .last         (last)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] millivolt_glyphs(input logic [SAMPLE_W-1:0] s);
    int unsigned mv;
    int unsigned thou;
    mv   = (32'(s) * 32'(reference_mv)) >> SAMPLE_W;
    thou = mv / 1000;
    if (thou > DIGIT_MAX) thou = 32'(DIGIT_MAX);
    return {DIGIT_GLYPH[4'(thou)] & SEG_DP_CLEAR,
            DIGIT_GLYPH[4'((mv / 100) % 10)],
            DIGIT_GLYPH[4'((mv / 10) % 10)],
            DIGIT_GLYPH[4'(mv % 10)]};
  endfunction

  function automatic void push_display(input logic [31:0] segs);
    pending_digits.push_back(display_digit_t'{segs[7:0],   SEL_ONES,      1'b0});
    pending_digits.push_back(display_digit_t'{segs[15:8],  SEL_TENS,      1'b0});
    pending_digits.push_back(display_digit_t'{segs[23:16], SEL_HUNDREDS,  1'b0});
    pending_digits.push_back(display_digit_t'{segs[31:24], SEL_THOUSANDS, 1'b1});
  endfunction

  // called and returns on a falling edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                             input logic [31:0] segs);
    while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      sample   <= SAMPLE_W'($urandom_range(SAMPLE_MAX));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    push_display(typed ? segs : millivolt_glyphs(s));
    @(negedge clk);
  endtask

  // hold the sender off until every digit has been displayed
  task automatic drain_display();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_digits.size() != 0);
  endtask

  task automatic write_reference(input logic [REF_BITS-1:0] v);
    drain_display();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write    <= 1'b0;
    reference_mv = v;
  endtask

  always @(negedge clk) begin
    out_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected transaction: segments=%h digit_select=%b last=%b",
               segments, digit_select, last);
        fail_count++;
      end else begin
        oldest = pending_digits.pop_front();
        if (segments !== oldest.segments) begin
          $error("segments: expected %h, got %h", oldest.segments, segments);
          fail_count++;
        end
        if (digit_select !== oldest.digit_select) begin
          $error("digit_select: expected %b, got %b", oldest.digit_select, digit_select);
          fail_count++;
        end
        if (last !== oldest.last) begin
          $error("last: expected %b, got %b", oldest.last, last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    directed_row_t       row;
    logic [REF_BITS-1:0] phase_ref;
    logic [SAMPLE_W-1:0] pick;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[5'(i)];
      if (row.set_ref) begin
        write_reference(row.value);
      end else begin
        send_sample(row.value[SAMPLE_W-1:0], row.typed, row.segs);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES - 1) begin
        phase_ref = PHASE_REF[3'(p)];
      end else begin
        phase_ref = REF_BITS'($urandom_range((1 << REF_BITS) - 1));
      end
      steady_run = (p == 1);
      write_reference(phase_ref);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_display();
        if ($urandom_range(99) < 20) begin
          case ($urandom_range(3))
            0:       pick = '0;
            1:       pick = SAMPLE_W'(SAMPLE_MAX);
            2:       pick = SAMPLE_W'(1);
            default: pick = SAMPLE_W'(1 << (SAMPLE_W - 1));
          endcase
        end else begin
          pick = SAMPLE_W'($urandom_range(SAMPLE_MAX));
        end
        send_sample(pick, 1'b0, 32'h0);
      end
    end
    steady_run = 1'b0;

    drain_display();
    repeat (SETTLE_TICKS) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/amss_pkg.sv
rtl/amss_scale.sv
rtl/amss_digits.sv
rtl/amss_serial.sv
rtl/adc_millivolt_seven_segment.sv
dv/adc_millivolt_seven_segment_tb.sv
